### src/pfre_pkg.sv
`timescale 1ns / 1ps
// Package for the point-to-plane RMS distance block: widths, register
// indexes, the configuration struct and the sequencer states.
// No dependencies; every other file of the block uses it.
package pfre_pkg;

	localparam int unsigned COORD_W    = 19;
	localparam int unsigned NORM_W     = 16;
	localparam int unsigned OFFS_W     = 19;
	localparam int unsigned RMS_W      = 24;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned MAX_POINTS = 65536;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned DATA_W     = 32;

	// Projection sum in units of 2^-14 mm and its derived widths.
	localparam int unsigned ACC_W   = 37;
	localparam int unsigned FRAC_SH = 14;
	localparam int unsigned RND_SH  = 10;
	localparam int unsigned MAG_W   = 26;
	localparam int unsigned MUL_W   = 27;
	localparam int unsigned PROD_W  = 2 * MUL_W;
	localparam int unsigned SQ_W    = 2 * MAG_W;
	localparam int unsigned SUM_W   = 64;

	// Divider and square root widths.
	localparam int unsigned ROOT_W = SUM_W / 2;
	localparam int unsigned REM_W  = ROOT_W + 3;
	localparam int unsigned STEP_W = 6;

	localparam logic [NORM_W-1:0] NORMAL_Z_RESET = NORM_W'(16384);

	typedef enum logic [1:0] {
		REG_NORMAL_X,
		REG_NORMAL_Y,
		REG_NORMAL_Z,
		REG_PLANE_OFFSET
	} reg_idx_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic signed [OFFS_W-1:0] plane_offset;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_ADD,
		ST_ABS,
		ST_SQ,
		ST_ACC,
		ST_FIN,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage

### src/pfre_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the point stream and the result stream.
// Depends on pfre_pkg for the field widths.
interface pfre_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [pfre_pkg::COORD_W-1:0] x_mm;
	logic signed [pfre_pkg::COORD_W-1:0] y_mm;
	logic signed [pfre_pkg::COORD_W-1:0] z_mm;
	logic                                point_valid;
	logic                                last_point;

	modport source (output valid, x_mm, y_mm, z_mm, point_valid, last_point, input ready);
	modport sink (input valid, x_mm, y_mm, z_mm, point_valid, last_point, output ready);
endinterface

interface pfre_result_if;
	logic                              valid;
	logic                              ready;
	logic [pfre_pkg::RMS_W-1:0]        rms_value;
	logic [pfre_pkg::CNT_W-1:0]        used_count;
	logic                              overflow;

	modport source (output valid, rms_value, used_count, overflow, input ready);
	modport sink (input valid, rms_value, used_count, overflow, output ready);
endinterface

### src/pfre_regs.sv
`timescale 1ns / 1ps
// APB-style register file holding the plane normal and offset.
// Depends on pfre_pkg for the register indexes and the cfg_t struct.
module pfre_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfre_pkg::ADDR_W-1:0]   paddr,
	input  logic [pfre_pkg::DATA_W-1:0]   pwdata,
	output logic [pfre_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pfre_pkg::cfg_t                cfg
);

	pfre_pkg::cfg_t   cfg_q;
	pfre_pkg::reg_idx_t reg_idx;
	logic             wr_en;

	assign reg_idx = pfre_pkg::reg_idx_t'(paddr[pfre_pkg::ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x     <= '0;
			cfg_q.normal_y     <= '0;
			cfg_q.normal_z     <= pfre_pkg::NORMAL_Z_RESET;
			cfg_q.plane_offset <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				pfre_pkg::REG_NORMAL_X:     cfg_q.normal_x <= pwdata[pfre_pkg::NORM_W-1:0];
				pfre_pkg::REG_NORMAL_Y:     cfg_q.normal_y <= pwdata[pfre_pkg::NORM_W-1:0];
				pfre_pkg::REG_NORMAL_Z:     cfg_q.normal_z <= pwdata[pfre_pkg::NORM_W-1:0];
				pfre_pkg::REG_PLANE_OFFSET: cfg_q.plane_offset <= pwdata[pfre_pkg::OFFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read mux returns the raw register bits.
	always_comb begin
		case (reg_idx)
			pfre_pkg::REG_NORMAL_X:     prdata = pfre_pkg::DATA_W'(unsigned'(cfg_q.normal_x));
			pfre_pkg::REG_NORMAL_Y:     prdata = pfre_pkg::DATA_W'(unsigned'(cfg_q.normal_y));
			pfre_pkg::REG_NORMAL_Z:     prdata = pfre_pkg::DATA_W'(unsigned'(cfg_q.normal_z));
			pfre_pkg::REG_PLANE_OFFSET: prdata = pfre_pkg::DATA_W'(unsigned'(cfg_q.plane_offset));
			default:                    prdata = '0;
		endcase
	end

endmodule

### src/plane_fit_rms_error.sv
`timescale 1ns / 1ps
// Point-to-plane RMS distance: top level with sequencer and shared datapath.
// Depends on pfre_pkg, the channel interfaces in pfre_if and pfre_regs.
//
// Usage: the plane normal (Q2.14) and offset (mm) are to be written over the
// APB port only while the block is idle; the block itself does not enforce
// this. Points arrive on the points channel, one word per handshake; results
// leave on the results channel, one word per cloud. A valid point runs
// through one shared 27x27 multiplier in seven steps (three projections,
// rounding, absolute value, square, saturating sum); a skipped point that is
// not marked last leaves the sequencer idle. The word marked last then runs
// a restoring divider (one quotient bit a cycle) and a digit-by-digit square
// root, both on one shared subtractor, and then loads the result register;
// a cloud with no used point goes straight to the load. points.ready is high
// only while the sequencer is idle. The result sits in an output register,
// so the next cloud is taken in while a result waits; only the final load
// stalls if the receiver still holds off the previous result.
// Reset clears the sums, the count, the overflow flag and the output valid,
// and sets the normal to (0, 0, 1) and the offset to 0.
module plane_fit_rms_error (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfre_pkg::ADDR_W-1:0]   paddr,
	input  logic [pfre_pkg::DATA_W-1:0]   pwdata,
	output logic [pfre_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	pfre_point_if.sink                    points,
	pfre_result_if.source                 results
);

	pfre_pkg::cfg_t   cfg;
	pfre_pkg::state_t state_q;
	pfre_pkg::state_t state_nxt;

	// Latched point.
	logic signed [pfre_pkg::COORD_W-1:0] x_q;
	logic signed [pfre_pkg::COORD_W-1:0] y_q;
	logic signed [pfre_pkg::COORD_W-1:0] z_q;
	logic                                last_q;

	// Accumulation state.
	logic signed [pfre_pkg::ACC_W-1:0]   acc_q;
	logic signed [pfre_pkg::PROD_W-1:0]  prod_q;
	logic [pfre_pkg::MAG_W-1:0]          mag_q;
	logic [pfre_pkg::SUM_W-1:0]          sum_q;
	logic [pfre_pkg::CNT_W-1:0]          point_count_q;
	logic                                overflow_q;

	// Divider and square root state.
	logic [pfre_pkg::SUM_W-1:0]          quo_q;
	logic [pfre_pkg::REM_W-1:0]          rem_q;
	logic [pfre_pkg::ROOT_W-1:0]         root_q;
	logic [pfre_pkg::STEP_W-1:0]         step_q;

	// Output register.
	logic                                out_valid_q;
	logic [pfre_pkg::RMS_W-1:0]          rms_out_q;
	logic [pfre_pkg::CNT_W-1:0]          count_out_q;
	logic                                ovf_out_q;

	// Combinational datapath signals.
	logic                                accept;
	logic                                take_point;
	logic                                out_free;
	logic signed [pfre_pkg::MUL_W-1:0]   mul_a;
	logic signed [pfre_pkg::MUL_W-1:0]   mul_b;
	logic signed [pfre_pkg::PROD_W-1:0]  prod_w;
	logic signed [pfre_pkg::ACC_W-1:0]   off_ext;
	logic signed [pfre_pkg::ACC_W-1:0]   acc_init;
	logic signed [pfre_pkg::ACC_W-1:0]   rnd_dist;
	logic [pfre_pkg::ACC_W-1:0]          abs_val;
	logic [pfre_pkg::SUM_W:0]            sum_ext;
	logic [pfre_pkg::REM_W-1:0]          sub_a;
	logic [pfre_pkg::REM_W-1:0]          sub_b;
	logic [pfre_pkg::REM_W:0]            diff;
	logic                                fits;
	logic [pfre_pkg::RMS_W-1:0]          rms_sat;

	pfre_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign points.ready = (state_q == pfre_pkg::ST_IDLE);
	assign accept       = points.valid & points.ready;
	assign take_point   = points.point_valid
	                    & (pfre_pkg::CNT_W'(pfre_pkg::MAX_POINTS) > point_count_q);
	assign out_free     = ~out_valid_q | results.ready;

	assign results.valid      = out_valid_q;
	assign results.rms_value  = rms_out_q;
	assign results.used_count = count_out_q;
	assign results.overflow   = ovf_out_q;

	// Shared multiplier operand select; the product is registered.
	always_comb begin
		case (state_q)
			pfre_pkg::ST_MX: begin
				mul_a = pfre_pkg::MUL_W'(cfg.normal_x);
				mul_b = pfre_pkg::MUL_W'(x_q);
			end
			pfre_pkg::ST_MY: begin
				mul_a = pfre_pkg::MUL_W'(cfg.normal_y);
				mul_b = pfre_pkg::MUL_W'(y_q);
			end
			pfre_pkg::ST_MZ: begin
				mul_a = pfre_pkg::MUL_W'(cfg.normal_z);
				mul_b = pfre_pkg::MUL_W'(z_q);
			end
			pfre_pkg::ST_SQ: begin
				mul_a = pfre_pkg::MUL_W'({1'b0, mag_q});
				mul_b = pfre_pkg::MUL_W'({1'b0, mag_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod_w = mul_a * mul_b;

	// Offset in 2^-14 mm plus half of the rounding step.
	assign off_ext  = pfre_pkg::ACC_W'(cfg.plane_offset);
	assign acc_init = (off_ext <<< pfre_pkg::FRAC_SH)
	                + pfre_pkg::ACC_W'(1 << (pfre_pkg::RND_SH - 1));

	// Rounded distance in 1/16 mm and its magnitude.
	assign rnd_dist = acc_q >>> pfre_pkg::RND_SH;
	assign abs_val  = rnd_dist[pfre_pkg::ACC_W-1] ? pfre_pkg::ACC_W'(-rnd_dist)
	                                              : pfre_pkg::ACC_W'(rnd_dist);

	// Saturating sum of squares.
	assign sum_ext = {1'b0, sum_q}
	               + (pfre_pkg::SUM_W + 1)'(prod_q[pfre_pkg::SQ_W-1:0]);

	// Shared subtractor for the divider and the square root.
	always_comb begin
		case (state_q)
			pfre_pkg::ST_DIV: begin
				sub_a = pfre_pkg::REM_W'({rem_q[pfre_pkg::CNT_W-1:0],
				                          quo_q[pfre_pkg::SUM_W-1]});
				sub_b = pfre_pkg::REM_W'(point_count_q);
			end
			pfre_pkg::ST_SQRT: begin
				sub_a = {rem_q[pfre_pkg::REM_W-3:0],
				         quo_q[pfre_pkg::SUM_W-1:pfre_pkg::SUM_W-2]};
				sub_b = {1'b0, root_q, 2'b01};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end
	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign fits = ~diff[pfre_pkg::REM_W];

	// Root above the output range clamps to all ones.
	assign rms_sat = (root_q[pfre_pkg::ROOT_W-1:pfre_pkg::RMS_W] != '0)
	               ? '1 : root_q[pfre_pkg::RMS_W-1:0];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfre_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pfre_pkg::ST_IDLE: begin
				if (accept) begin
					if (take_point) begin
						state_nxt = pfre_pkg::ST_MX;
					end else if (points.last_point) begin
						state_nxt = pfre_pkg::ST_FIN;
					end
				end
			end
			pfre_pkg::ST_MX:  state_nxt = pfre_pkg::ST_MY;
			pfre_pkg::ST_MY:  state_nxt = pfre_pkg::ST_MZ;
			pfre_pkg::ST_MZ:  state_nxt = pfre_pkg::ST_ADD;
			pfre_pkg::ST_ADD: state_nxt = pfre_pkg::ST_ABS;
			pfre_pkg::ST_ABS: state_nxt = pfre_pkg::ST_SQ;
			pfre_pkg::ST_SQ:  state_nxt = pfre_pkg::ST_ACC;
			pfre_pkg::ST_ACC: begin
				state_nxt = last_q ? pfre_pkg::ST_FIN : pfre_pkg::ST_IDLE;
			end
			pfre_pkg::ST_FIN: begin
				state_nxt = (point_count_q == '0) ? pfre_pkg::ST_OUT : pfre_pkg::ST_DIV;
			end
			pfre_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_nxt = pfre_pkg::ST_SQRT;
				end
			end
			pfre_pkg::ST_SQRT: begin
				if (step_q == '0) begin
					state_nxt = pfre_pkg::ST_OUT;
				end
			end
			pfre_pkg::ST_OUT: begin
				if (out_free) begin
					state_nxt = pfre_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pfre_pkg::ST_IDLE;
		endcase
	end

	// Control state: count, overflow flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			overflow_q    <= 1'b0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// A new result takes precedence over the receiver taking the old one.
			if (state_q == pfre_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pfre_pkg::ST_IDLE: begin
					if (accept && points.point_valid && !take_point) begin
						overflow_q <= 1'b1;
					end
				end
				pfre_pkg::ST_ACC: begin
					sum_q         <= sum_ext[pfre_pkg::SUM_W] ? '1
					                 : sum_ext[pfre_pkg::SUM_W-1:0];
					point_count_q <= point_count_q + 1'b1;
				end
				pfre_pkg::ST_OUT: begin
					if (out_free) begin
						point_count_q <= '0;
						overflow_q    <= 1'b0;
						sum_q         <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= prod_w;
		case (state_q)
			pfre_pkg::ST_IDLE: begin
				if (accept) begin
					x_q    <= points.x_mm;
					y_q    <= points.y_mm;
					z_q    <= points.z_mm;
					last_q <= points.last_point;
					acc_q  <= acc_init;
				end
			end
			pfre_pkg::ST_MY, pfre_pkg::ST_MZ, pfre_pkg::ST_ADD: begin
				acc_q <= acc_q + prod_q[pfre_pkg::ACC_W-1:0];
			end
			pfre_pkg::ST_ABS: begin
				mag_q <= abs_val[pfre_pkg::MAG_W-1:0];
			end
			pfre_pkg::ST_FIN: begin
				quo_q  <= sum_q;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= pfre_pkg::STEP_W'(pfre_pkg::SUM_W - 1);
			end
			pfre_pkg::ST_DIV: begin
				quo_q <= {quo_q[pfre_pkg::SUM_W-2:0], fits};
				// The last quotient bit hands over to the square root.
				if (step_q == '0) begin
					rem_q  <= '0;
					step_q <= pfre_pkg::STEP_W'(pfre_pkg::ROOT_W - 1);
				end else begin
					rem_q  <= fits ? diff[pfre_pkg::REM_W-1:0] : sub_a;
					step_q <= step_q - 1'b1;
				end
			end
			pfre_pkg::ST_SQRT: begin
				rem_q  <= fits ? diff[pfre_pkg::REM_W-1:0] : sub_a;
				quo_q  <= {quo_q[pfre_pkg::SUM_W-3:0], 2'b00};
				root_q <= {root_q[pfre_pkg::ROOT_W-2:0], fits};
				step_q <= step_q - 1'b1;
			end
			pfre_pkg::ST_OUT: begin
				if (out_free) begin
					rms_out_q   <= rms_sat;
					count_out_q <= point_count_q;
					ovf_out_q   <= overflow_q;
				end
			end
			default: begin
			end
		endcase
	end

	// The count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_count_q <= pfre_pkg::CNT_W'(pfre_pkg::MAX_POINTS))
		else $error("point count above capacity");

	// Overflow is only flagged once the capacity is used up.
	assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> point_count_q == pfre_pkg::CNT_W'(pfre_pkg::MAX_POINTS))
		else $error("overflow flagged below capacity");

	// The divider remainder stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfre_pkg::ST_DIV |-> rem_q < pfre_pkg::REM_W'(point_count_q))
		else $error("divider remainder not below divisor");

	// The square root runs at most one step per root bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfre_pkg::ST_SQRT |-> step_q < pfre_pkg::STEP_W'(pfre_pkg::ROOT_W))
		else $error("square root step out of range");

	// Loading a result clears the cloud state and shows the word.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfre_pkg::ST_OUT && out_free |=>
			state_q == pfre_pkg::ST_IDLE && point_count_q == '0 && out_valid_q)
		else $error("result load did not clear state");

endmodule

### verif/plane_fit_rms_error_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for plane_fit_rms_error: point clouds go in over the
// point channel, RMS results are checked against an in-bench predictor.
// Depends on pfre_pkg, the channel interfaces in pfre_if and the block itself.
module plane_fit_rms_error_tb;

	localparam int HALF_PERIOD   = 6;
	localparam int DRAIN_CYCLES  = 200;
	localparam int HOLD_CYCLES   = 800;
	localparam int PHASE_ITEMS   = 250;
	localparam int END_WAIT_MAX  = 20000;
	localparam int PRINT_MAX     = 40;

	localparam logic [pfre_pkg::COORD_W-1:0] COORD_MIN = 19'h40000;
	localparam logic [pfre_pkg::COORD_W-1:0] COORD_MAX = 19'h3FFFF;

	typedef struct packed {
		logic signed [pfre_pkg::COORD_W-1:0] x_mm;
		logic signed [pfre_pkg::COORD_W-1:0] y_mm;
		logic signed [pfre_pkg::COORD_W-1:0] z_mm;
		logic                                point_valid;
		logic                                last_point;
	} point_t;

	typedef struct packed {
		logic [pfre_pkg::RMS_W-1:0] rms_value;
		logic [pfre_pkg::CNT_W-1:0] used_count;
		logic                       overflow;
	} cloud_result_t;

	// Tracks the plane, the running sums of the open cloud and the results
	// still owed by the block.
	class plane_rms_tracker;
		logic signed [pfre_pkg::NORM_W-1:0] nx, ny, nz;
		logic signed [pfre_pkg::OFFS_W-1:0] offs;
		longint unsigned                    sq_sum;
		int unsigned                        n_used;
		bit                                 ovf;
		cloud_result_t                      expected_clouds[$];
		int                                 errors;

		function new();
			nx = '0;
			ny = '0;
			nz = pfre_pkg::NORMAL_Z_RESET;
			offs = '0;
			sq_sum = 0;
			n_used = 0;
			ovf = 0;
			errors = 0;
		endfunction

		function void set_reg(pfre_pkg::reg_idx_t idx, logic [pfre_pkg::DATA_W-1:0] val);
			case (idx)
				pfre_pkg::REG_NORMAL_X: nx = val[pfre_pkg::NORM_W-1:0];
				pfre_pkg::REG_NORMAL_Y: ny = val[pfre_pkg::NORM_W-1:0];
				pfre_pkg::REG_NORMAL_Z: nz = val[pfre_pkg::NORM_W-1:0];
				pfre_pkg::REG_PLANE_OFFSET: offs = val[pfre_pkg::OFFS_W-1:0];
				default: ;
			endcase
		endfunction

		// Floor square root, one result bit at a time from the top.
		function longint unsigned floor_root(longint unsigned v);
			longint unsigned r, t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v)
					r = t;
			end
			return r;
		endfunction

		function void note_point(point_t p);
			longint          proj, dist16;
			longint unsigned mag, sq, root;
			cloud_result_t   want;
			if (p.point_valid) begin
				if (n_used < pfre_pkg::MAX_POINTS) begin
					proj = longint'(nx) * longint'($signed(p.x_mm))
						+ longint'(ny) * longint'($signed(p.y_mm))
						+ longint'(nz) * longint'($signed(p.z_mm))
						+ (longint'(offs) <<< pfre_pkg::FRAC_SH);
					// Round to 1/16 mm, ties toward plus infinity.
					dist16 = (proj + 512) >>> pfre_pkg::RND_SH;
					mag = (dist16 < 0) ? longint'(-dist16) : longint'(dist16);
					sq = mag * mag;
					if (sq_sum > ~64'd0 - sq)
						sq_sum = ~64'd0;
					else
						sq_sum = sq_sum + sq;
					n_used++;
				end else begin
					ovf = 1;
				end
			end
			if (!p.last_point)
				return;
			root = 0;
			if (n_used != 0) begin
				root = floor_root(sq_sum / longint'(n_used));
				if (root > 64'hFFFFFF)
					root = 64'hFFFFFF;
			end
			want.rms_value = root[pfre_pkg::RMS_W-1:0];
			want.used_count = pfre_pkg::CNT_W'(n_used);
			want.overflow = ovf;
			expected_clouds = {expected_clouds, want};
			sq_sum = 0;
			n_used = 0;
			ovf = 0;
		endfunction

		function int pending();
			return expected_clouds.size();
		endfunction

		task report(string msg);
			if (errors < PRINT_MAX)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(cloud_result_t got);
			cloud_result_t want;
			if (expected_clouds.size() == 0) begin
				report($sformatf("unexpected result rms %0d count %0d overflow %0b",
					got.rms_value, got.used_count, got.overflow));
				return;
			end
			want = expected_clouds.pop_front();
			if (got.rms_value !== want.rms_value)
				report($sformatf("rms_value %0d, predicted %0d", got.rms_value, want.rms_value));
			if (got.used_count !== want.used_count)
				report($sformatf("used_count %0d, predicted %0d", got.used_count, want.used_count));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow %0b, predicted %0b", got.overflow, want.overflow));
		endtask

		task flush_check();
			while (expected_clouds.size() != 0) begin
				report($sformatf("result never came: rms %0d count %0d",
					expected_clouds[0].rms_value, expected_clouds[0].used_count));
				void'(expected_clouds.pop_front());
			end
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [pfre_pkg::ADDR_W-1:0] paddr;
	logic [pfre_pkg::DATA_W-1:0] pwdata;
	logic [pfre_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	pfre_point_if  pt ();
	pfre_result_if rs ();

	plane_rms_tracker tracker = new();

	bit hold_req;
	int burst_left;
	int counted_items;

	plane_fit_rms_error u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.points  (pt),
		.results (rs)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Every accepted result word is checked at the edge that takes it.
	always @(posedge clk) begin
		cloud_result_t got;
		if (rs.valid && rs.ready) begin
			got.rms_value = rs.rms_value;
			got.used_count = rs.used_count;
			got.overflow = rs.overflow;
			tracker.check_result(got);
		end
	end

	// Result receiver: a changing stall pattern, plus a long hold-off on request.
	initial begin : result_sink
		int mode, mode_left, k;
		rs.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		k = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rs.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				k++;
				case (mode)
					0: rs.ready = 1'b1;
					1: rs.ready = 1'($urandom_range(0, 1));
					2: rs.ready = ($urandom_range(0, 3) == 0);
					default: rs.ready = ((k % 7) < 3);
				endcase
			end
		end
	end

	// Safety net against a hung handshake.
	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// APB register write: setup cycle, then access cycle until pready.
	task automatic apb_write(pfre_pkg::reg_idx_t idx, logic [pfre_pkg::DATA_W-1:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.set_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_plane(logic [pfre_pkg::DATA_W-1:0] x, logic [pfre_pkg::DATA_W-1:0] y,
		logic [pfre_pkg::DATA_W-1:0] z, logic [pfre_pkg::DATA_W-1:0] d);
		apb_write(pfre_pkg::REG_NORMAL_X, x);
		apb_write(pfre_pkg::REG_NORMAL_Y, y);
		apb_write(pfre_pkg::REG_NORMAL_Z, z);
		apb_write(pfre_pkg::REG_PLANE_OFFSET, d);
	endtask

	// Offer one point word in bursts with random gaps between them.
	task automatic send_point(point_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				pt.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pt.valid = 1'b1;
		pt.x_mm = p.x_mm;
		pt.y_mm = p.y_mm;
		pt.z_mm = p.z_mm;
		pt.point_valid = p.point_valid;
		pt.last_point = p.last_point;
		@(posedge clk);
		while (!pt.ready) @(posedge clk);
		tracker.note_point(p);
		counted_items++;
		@(negedge clk);
	endtask

	task automatic send_xyz(int x, int y, int z, bit pv, bit last);
		point_t p;
		p.x_mm = x[pfre_pkg::COORD_W-1:0];
		p.y_mm = y[pfre_pkg::COORD_W-1:0];
		p.z_mm = z[pfre_pkg::COORD_W-1:0];
		p.point_valid = pv;
		p.last_point = last;
		send_point(p);
	endtask

	// Stop offering words and wait until the block has gone quiet.
	task automatic settle();
		pt.valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [pfre_pkg::COORD_W-1:0] rand_coord();
		int v;
		case ($urandom_range(0, 7))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3: begin
				v = int'($urandom_range(0, 4000)) - 2000;
				return v[pfre_pkg::COORD_W-1:0];
			end
			default: return pfre_pkg::COORD_W'($urandom());
		endcase
	endfunction

	// One cloud of random points; the last word always closes it.
	task automatic send_cloud(int len, bit noise);
		point_t p;
		for (int i = 0; i < len; i++) begin
			p.x_mm = rand_coord();
			p.y_mm = rand_coord();
			p.z_mm = rand_coord();
			p.point_valid = noise ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 6) != 0);
			p.last_point = (i == len - 1);
			send_point(p);
		end
	endtask

	task automatic random_phase(bit short_clouds);
		int start, len;
		start = counted_items;
		while (counted_items - start < PHASE_ITEMS) begin
			if (short_clouds)
				len = $urandom_range(1, 4);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(20, 60);
			else
				len = $urandom_range(1, 8);
			send_cloud(len, $urandom_range(0, 7) == 0);
		end
	endtask

	// Main sequence: reset, directed clouds, random phases.
	initial begin : stimulus
		int waited;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pt.valid = 1'b0;
		pt.x_mm = '0;
		pt.y_mm = '0;
		pt.z_mm = '0;
		pt.point_valid = 1'b0;
		pt.last_point = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		counted_items = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset plane z = 0: no valid point, a lone point, coordinate extremes.
		send_xyz(0, 0, 0, 1'b0, 1'b1);
		send_xyz(0, 0, 0, 1'b1, 1'b1);
		send_xyz(262143, -262144, 262143, 1'b1, 1'b0);
		send_xyz(-262144, 262143, -262144, 1'b1, 1'b0);
		send_xyz(5, 5, 5, 1'b0, 1'b0);
		send_xyz(0, 0, 1, 1'b1, 1'b1);
		settle();

		// Plane x = 0 with a unit of 2^-14: rounding ties on both signs.
		set_plane(32'd1, 32'd0, 32'd0, 32'd0);
		send_xyz(512, 0, 0, 1'b1, 1'b1);
		send_xyz(-512, 0, 0, 1'b1, 1'b1);
		send_xyz(-513, 0, 0, 1'b1, 1'b1);
		send_xyz(511, 0, 0, 1'b1, 1'b0);
		send_xyz(1535, 0, 0, 1'b1, 1'b0);
		send_xyz(-1536, 0, 0, 1'b1, 1'b1);
		settle();

		// Full negative normal patterns and largest offset: RMS saturates.
		set_plane(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0003_FFFF);
		send_xyz(-262144, -262144, -262144, 1'b1, 1'b1);
		send_xyz(262143, 262143, 262143, 1'b1, 1'b1);
		settle();

		// Random phases, each under a different plane.
		set_plane(int'($urandom_range(0, 32768)) - 16384, int'($urandom_range(0, 32768)) - 16384,
			int'($urandom_range(0, 32768)) - 16384, int'($urandom_range(0, 524287)) - 262144);
		random_phase(1'b0);
		settle();

		set_plane(32'd16384, -32'sd16384, 32'd16384, 32'd262143);
		random_phase(1'b0);
		settle();

		// Long receiver hold-off while short clouds keep coming.
		set_plane(-32'sd16384, 32'd16384, -32'sd16384, -32'sd262144);
		hold_req = 1'b1;
		random_phase(1'b1);
		settle();

		set_plane($urandom(), $urandom(), $urandom(), $urandom());
		random_phase(1'b0);
		settle();

		set_plane(32'd0, 32'd0, 32'd0, $urandom());
		random_phase(1'b0);
		settle();

		set_plane(32'h0000_7FFF, 32'h0000_8000, 32'h0000_7FFF, $urandom());
		random_phase(1'b0);

		// Drain, then let the datapath run out before the verdict.
		pt.valid = 1'b0;
		waited = 0;
		while (tracker.pending() != 0 && waited < END_WAIT_MAX) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		tracker.flush_check();
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
